@@ rtl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the scan code key table: operation and status
// encodings, field widths and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int OpW     = 2;
  localparam int CountW  = 3;
  localparam int CodeW   = 16;
  localparam int StatusW = 2;
  localparam int IndexW  = 8;

  // number of code fields on the input port
  localparam int InputCodes = 4;

  localparam logic [OpW-1:0] OP_ADD    = 2'd0;
  localparam logic [OpW-1:0] OP_EXACT  = 2'd1;
  localparam logic [OpW-1:0] OP_PREFIX = 2'd2;
  localparam logic [OpW-1:0] OP_NONE   = 2'd3;

  localparam logic [StatusW-1:0] ST_OK         = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL       = 2'd2;
  localparam logic [StatusW-1:0] ST_BAD_LENGTH = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the input item
    logic direct;  // resolve add, bad length or unused operation
    logic start;   // arm the table walk
    logic step;    // advance the table walk
    logic found;   // record the hit
    logic miss;    // record no match
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_req;
    logic hit;
    logic exhausted;
  } sts_t;

endpackage

@@ rtl/skt_ctrl.sv @@
// ----------------------------------------------------------------------------
// skt_ctrl
// Controller: input/output handshake and sequencing of decode, table walk
// and result hand-off.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  skt_pkg::sts_t sts_i,
  output skt_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.search_req) begin
          cmd_o.start = 1'b1;
          state_d     = S_SEARCH;
        end else begin
          cmd_o.direct = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_SEARCH: begin
        cmd_o.step = 1'b1;
        if (sts_i.hit) begin
          cmd_o.found = 1'b1;
          state_d     = S_RESP;
        end else if (sts_i.exhausted) begin
          cmd_o.miss = 1'b1;
          state_d    = S_RESP;
        end
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/skt_dp.sv @@
// ----------------------------------------------------------------------------
// skt_dp
// Datapath: captured query, entry memory with registered read, newest-first
// walk counter, entry compare and result registers.
// ----------------------------------------------------------------------------
module skt_dp #(
  parameter int MAX_CODES     = 4,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [skt_pkg::OpW-1:0]      operation_i,
  input  logic [skt_pkg::CountW-1:0]   code_count_i,
  input  logic [skt_pkg::CodeW-1:0]    code_0_i,
  input  logic [skt_pkg::CodeW-1:0]    code_1_i,
  input  logic [skt_pkg::CodeW-1:0]    code_2_i,
  input  logic [skt_pkg::CodeW-1:0]    code_3_i,
  input  skt_pkg::cmd_t                cmd_i,
  output skt_pkg::sts_t                sts_o,
  output logic [skt_pkg::StatusW-1:0]  status_o,
  output logic [skt_pkg::IndexW-1:0]   entry_index_o
);

  localparam int StoredCodes = (MAX_CODES < skt_pkg::InputCodes) ? MAX_CODES
                                                                 : skt_pkg::InputCodes;
  localparam int IdxW   = $clog2(TABLE_ENTRIES);
  localparam int FillW  = $clog2(TABLE_ENTRIES + 1);
  localparam int CodesW = StoredCodes * skt_pkg::CodeW;
  localparam int EntryW = CodesW + skt_pkg::CountW;

  logic [skt_pkg::InputCodes-1:0][skt_pkg::CodeW-1:0] in_codes;
  logic [StoredCodes-1:0][skt_pkg::CodeW-1:0]         query_d, query_q;
  logic [skt_pkg::OpW-1:0]                            op_q;
  logic [skt_pkg::CountW-1:0]                         count_q;

  logic [EntryW-1:0] mem [TABLE_ENTRIES];
  logic [EntryW-1:0] rd_data_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              rd_vld_q;
  logic [FillW-1:0]  fill_q;
  logic [FillW-1:0]  cnt_q;
  logic [FillW-1:0]  cnt_m1;
  logic [IdxW-1:0]   rd_addr;
  logic              issue;

  logic              bad_len;
  logic              full;
  logic              wr_en;
  logic [EntryW-1:0] wr_data;

  logic [StoredCodes-1:0][skt_pkg::CodeW-1:0] rd_codes;
  logic [skt_pkg::CountW-1:0]                 rd_len;
  logic                                       codes_eq;
  logic                                       len_ok;

  logic [skt_pkg::StatusW-1:0] status_d, status_q;
  logic [IdxW-1:0]             index_d, index_q;
  logic                        res_en;
  logic [IdxW+skt_pkg::IndexW-1:0] idx_ext;

  assign in_codes = {code_3_i, code_2_i, code_1_i, code_0_i};

  // codes beyond the count are stored as zero
  always_comb begin
    for (int k = 0; k < StoredCodes; k++) begin
      query_d[k] = (skt_pkg::CountW'(k) < code_count_i) ? in_codes[k] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      count_q <= code_count_i;
      query_q <= query_d;
    end
  end

  assign bad_len = (count_q == '0) || (int'(count_q) > MAX_CODES) ||
                   (int'(count_q) > skt_pkg::InputCodes);
  assign full    = (fill_q == FillW'(TABLE_ENTRIES));
  assign wr_en   = cmd_i.direct && (op_q == skt_pkg::OP_ADD) && !bad_len && !full;
  assign wr_data = {count_q, query_q};

  // walk goes from the newest entry down to index 0
  assign cnt_m1  = cnt_q - 1'b1;
  assign rd_addr = cnt_m1[IdxW-1:0];
  assign issue   = cmd_i.step && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[IdxW-1:0]] <= wr_data;
    end
    if (issue) begin
      rd_data_q <= mem[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.start) begin
        cnt_q    <= fill_q;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.step) begin
        if (issue) begin
          cnt_q <= cnt_m1;
        end
        rd_vld_q <= issue;
      end
    end
  end

  assign rd_codes = rd_data_q[CodesW-1:0];
  assign rd_len   = rd_data_q[EntryW-1 -: skt_pkg::CountW];

  always_comb begin
    codes_eq = 1'b1;
    for (int k = 0; k < StoredCodes; k++) begin
      if ((skt_pkg::CountW'(k) < count_q) && (rd_codes[k] != query_q[k])) begin
        codes_eq = 1'b0;
      end
    end
  end

  assign len_ok = (op_q == skt_pkg::OP_PREFIX) ? (rd_len >= count_q) : (rd_len == count_q);

  assign sts_o.search_req = !bad_len &&
                            ((op_q == skt_pkg::OP_EXACT) || (op_q == skt_pkg::OP_PREFIX));
  assign sts_o.hit        = rd_vld_q && len_ok && codes_eq;
  assign sts_o.exhausted  = (cnt_q == '0) && !rd_vld_q;

  always_comb begin
    status_d = skt_pkg::ST_NOT_FOUND;
    index_d  = '0;
    if (cmd_i.found) begin
      status_d = skt_pkg::ST_OK;
      index_d  = rd_idx_q;
    end else if (cmd_i.direct) begin
      if (op_q == skt_pkg::OP_NONE) begin
        status_d = skt_pkg::ST_NOT_FOUND;
      end else if (bad_len) begin
        status_d = skt_pkg::ST_BAD_LENGTH;
      end else if (full) begin
        status_d = skt_pkg::ST_FULL;
      end else begin
        status_d = skt_pkg::ST_OK;
        index_d  = fill_q[IdxW-1:0];
      end
    end
  end

  assign res_en = cmd_i.found || cmd_i.miss || cmd_i.direct;

  always_ff @(posedge clk_i) begin
    if (res_en) begin
      status_q <= status_d;
      index_q  <= index_d;
    end
  end

  assign idx_ext       = {{skt_pkg::IndexW{1'b0}}, index_q};
  assign status_o      = status_q;
  assign entry_index_o = idx_ext[skt_pkg::IndexW-1:0];

endmodule

@@ rtl/scan_code_key_table.sv @@
// add, bad length and unused operation: decided in S_DECIDE, result offered from S_RESP after accept
// search: one stored entry read per cycle through the
//   single registered read port of the entry memory, newest entry first, stops at a hit
// throughput: one item at a time, next item accepted the cycle after the result is taken
// reset: clears the fill count and controller; entry memory is not cleared, no clear pass
// ----------------------------------------------------------------------------
// scan_code_key_table
// Key table of scan code sequences with add, exact search and prefix search.
// ----------------------------------------------------------------------------
module scan_code_key_table #(
  parameter int MAX_CODES     = 4,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [skt_pkg::OpW-1:0]      operation_i,
  input  logic [skt_pkg::CountW-1:0]   code_count_i,
  input  logic [skt_pkg::CodeW-1:0]    code_0_i,
  input  logic [skt_pkg::CodeW-1:0]    code_1_i,
  input  logic [skt_pkg::CodeW-1:0]    code_2_i,
  input  logic [skt_pkg::CodeW-1:0]    code_3_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [skt_pkg::StatusW-1:0]  status_o,
  output logic [skt_pkg::IndexW-1:0]   entry_index_o
);

  skt_pkg::cmd_t cmd;
  skt_pkg::sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  skt_dp #(
    .MAX_CODES     (MAX_CODES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (operation_i),
    .code_count_i  (code_count_i),
    .code_0_i      (code_0_i),
    .code_1_i      (code_1_i),
    .code_2_i      (code_2_i),
    .code_3_i      (code_3_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .entry_index_o (entry_index_o)
  );

endmodule

@@ test/scan_code_key_table_check.sv @@
// ----------------------------------------------------------------------------
// scan_code_key_table_check
// Watches both channels of the key table, keeps its own copy of the stored
// key sequences, works out the answer for every accepted item and compares
// each returned result with the oldest answer still due.
// ----------------------------------------------------------------------------
module scan_code_key_table_check #(
  parameter int MaxCodes     = 4,
  parameter int TableEntries = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [skt_pkg::OpW-1:0]      operation_i,
  input  logic [skt_pkg::CountW-1:0]   code_count_i,
  input  logic [skt_pkg::CodeW-1:0]    code_0_i,
  input  logic [skt_pkg::CodeW-1:0]    code_1_i,
  input  logic [skt_pkg::CodeW-1:0]    code_2_i,
  input  logic [skt_pkg::CodeW-1:0]    code_3_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [skt_pkg::StatusW-1:0]  status_i,
  input  logic [skt_pkg::IndexW-1:0]   entry_index_i,
  output int                           error_count_o,
  output int                           pending_o,
  output int                           found_count_o,
  output int                           full_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [skt_pkg::InputCodes-1:0][skt_pkg::CodeW-1:0] key_seq_t;

  typedef struct packed {
    logic [skt_pkg::StatusW-1:0] status;
    logic [skt_pkg::IndexW-1:0]  index;
  } key_answer_t;

  key_answer_t answers_due[$];

  logic [skt_pkg::CodeW-1:0] stored_codes [TableEntries][MaxCodes];
  int                        stored_len   [TableEntries];
  int                        stored_fill  = 0;

  int err_total     = 0;
  int found_total   = 0;
  int full_total    = 0;
  int pending_total = 0;
  int results_seen  = 0;

  assign error_count_o = err_total;
  assign found_count_o = found_total;
  assign full_count_o  = full_total;
  assign pending_o     = pending_total;

  task automatic report_mismatch(input string msg);
    $display("%0t ns  result %0d mismatch: %s", $realtime, results_seen, msg);
    err_total++;
  endtask

  // applies one item to the local key store and returns the answer it earns
  function automatic key_answer_t resolve_key(input logic [skt_pkg::OpW-1:0] op,
                                              input logic [skt_pkg::CountW-1:0] cnt,
                                              input key_seq_t codes);
    key_answer_t               ans;
    logic [skt_pkg::CodeW-1:0] query [skt_pkg::InputCodes];
    logic                      hit;
    int                        i;
    int                        k;
    ans.status = skt_pkg::ST_NOT_FOUND;
    ans.index  = '0;
    hit = 1'b0;
    for (k = 0; k < skt_pkg::InputCodes; k++) begin
      query[k] = (k < cnt) ? codes[k] : '0;
    end
    if (op == skt_pkg::OP_NONE) begin
      ans.status = skt_pkg::ST_NOT_FOUND;
    end else if (cnt == 0 || cnt > MaxCodes || cnt > skt_pkg::InputCodes) begin
      ans.status = skt_pkg::ST_BAD_LENGTH;
    end else if (op == skt_pkg::OP_ADD) begin
      if (stored_fill >= TableEntries) begin
        ans.status = skt_pkg::ST_FULL;
      end else begin
        for (k = 0; k < MaxCodes; k++) begin
          stored_codes[stored_fill][k] = (k < cnt && k < skt_pkg::InputCodes) ? query[k] : '0;
        end
        stored_len[stored_fill] = cnt;
        ans.status = skt_pkg::ST_OK;
        ans.index  = skt_pkg::IndexW'(stored_fill);
        stored_fill++;
      end
    end else begin
      // newest entry first; a prefix hit needs the stored key at least as long
      for (i = stored_fill - 1; i >= 0 && !hit; i--) begin
        if (op == skt_pkg::OP_PREFIX ? (stored_len[i] >= cnt) : (stored_len[i] == cnt)) begin
          hit = 1'b1;
          for (k = 0; k < cnt && k < MaxCodes; k++) begin
            if (stored_codes[i][k] != query[k]) hit = 1'b0;
          end
          if (hit) begin
            ans.status = skt_pkg::ST_OK;
            ans.index  = skt_pkg::IndexW'(i);
          end
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i) begin
    key_answer_t want;
    key_answer_t ans;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d index %0d",
                                    status_i, entry_index_i));
        end else begin
          want = answers_due.pop_front();
          if (status_i !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_i, want.status));
          if (entry_index_i !== want.index)
            report_mismatch($sformatf("entry_index got %0d want %0d",
                                      entry_index_i, want.index));
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        ans = resolve_key(operation_i, code_count_i,
                          {code_3_i, code_2_i, code_1_i, code_0_i});
        if (operation_i inside {skt_pkg::OP_EXACT, skt_pkg::OP_PREFIX} &&
            ans.status == skt_pkg::ST_OK) found_total++;
        if (ans.status == skt_pkg::ST_FULL) full_total++;
        answers_due = {answers_due, ans};
      end
      pending_total <= answers_due.size();
    end
  end

endmodule

@@ test/scan_code_key_table_test.sv @@
// ----------------------------------------------------------------------------
// scan_code_key_table_test
// Drives adds, exact and prefix searches into the key table through four
// handshake phases, fills the table to the limit and lets the checker judge
// every result.
// ----------------------------------------------------------------------------
module scan_code_key_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxCodes     = 4;
  localparam int TableEntries = 256;
  localparam int RandomItems  = 2000;
  localparam int DrainCycles  = 300;

  typedef logic [skt_pkg::InputCodes-1:0][skt_pkg::CodeW-1:0] key_seq_t;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_valid   = 1'b0;
  logic                        in_ready;
  logic [skt_pkg::OpW-1:0]     operation  = skt_pkg::OP_NONE;
  logic [skt_pkg::CountW-1:0]  code_count = '0;
  logic [skt_pkg::CodeW-1:0]   code_0     = '0;
  logic [skt_pkg::CodeW-1:0]   code_1     = '0;
  logic [skt_pkg::CodeW-1:0]   code_2     = '0;
  logic [skt_pkg::CodeW-1:0]   code_3     = '0;
  logic                        out_valid;
  logic                        out_ready  = 1'b0;
  logic [skt_pkg::StatusW-1:0] status;
  logic [skt_pkg::IndexW-1:0]  entry_index;

  int error_count;
  int pending;
  int found_count;
  int full_count;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int items_sent = 0;

  // keys added so far, used to aim searches at stored entries
  key_seq_t known_codes[$];
  int       known_len[$];

  int idle_plan  [4] = '{0, 57, 0, 31};
  int stall_plan [4] = '{0, 0, 57, 31};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  scan_code_key_table #(
    .MAX_CODES     (MaxCodes),
    .TABLE_ENTRIES (TableEntries)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .operation_i   (operation),
    .code_count_i  (code_count),
    .code_0_i      (code_0),
    .code_1_i      (code_1),
    .code_2_i      (code_2),
    .code_3_i      (code_3),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .entry_index_o (entry_index)
  );

  scan_code_key_table_check #(
    .MaxCodes     (MaxCodes),
    .TableEntries (TableEntries)
  ) u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .operation_i   (operation),
    .code_count_i  (code_count),
    .code_0_i      (code_0),
    .code_1_i      (code_1),
    .code_2_i      (code_2),
    .code_3_i      (code_3),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .entry_index_i (entry_index),
    .error_count_o (error_count),
    .pending_o     (pending),
    .found_count_o (found_count),
    .full_count_o  (full_count)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // half of the codes come from a small pool so keys collide and share prefixes
  function automatic logic [skt_pkg::CodeW-1:0] draw_scan_code();
    logic [skt_pkg::CodeW-1:0] c;
    case ($urandom_range(0, 7))
      0:       c = 16'h0000;
      1:       c = 16'hFFFF;
      2:       c = 16'h001C;
      3:       c = 16'hE01C;
      default: c = skt_pkg::CodeW'($urandom_range(0, 65535));
    endcase
    return c;
  endfunction

  task automatic send_key_item(input logic [skt_pkg::OpW-1:0] op,
                               input logic [skt_pkg::CountW-1:0] cnt,
                               input key_seq_t codes);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    code_count <= cnt;
    code_0     <= codes[0];
    code_1     <= codes[1];
    code_2     <= codes[2];
    code_3     <= codes[3];
    do @(posedge clk); while (!in_ready);
    if (op == skt_pkg::OP_ADD && cnt >= 1 && cnt <= MaxCodes &&
        known_codes.size() < TableEntries) begin
      known_codes = {known_codes, codes};
      known_len   = {known_len, int'(cnt)};
    end
    items_sent++;
  endtask

  // codes are listed {code_3, code_2, code_1, code_0}; slots past the count are junk
  task automatic directed_keys();
    send_key_item(skt_pkg::OP_EXACT,  1, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000});
    send_key_item(skt_pkg::OP_PREFIX, 1, {16'h0000, 16'h0000, 16'h0000, 16'h001C});
    send_key_item(skt_pkg::OP_ADD,    1, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000});
    send_key_item(skt_pkg::OP_ADD,    4, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_key_item(skt_pkg::OP_ADD,    2, {16'hAAAA, 16'h5555, 16'hE01C, 16'h001C});
    send_key_item(skt_pkg::OP_ADD,    3, {16'hFFFF, 16'h0001, 16'hE01C, 16'h001C});
    send_key_item(skt_pkg::OP_ADD,    2, {16'h0000, 16'h0000, 16'hE01C, 16'h001C});
    send_key_item(skt_pkg::OP_EXACT,  2, {16'h1234, 16'h5678, 16'hE01C, 16'h001C});
    send_key_item(skt_pkg::OP_PREFIX, 1, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h001C});
    send_key_item(skt_pkg::OP_PREFIX, 3, {16'h0000, 16'h0001, 16'hE01C, 16'h001C});
    send_key_item(skt_pkg::OP_EXACT,  3, {16'h0000, 16'h0002, 16'hE01C, 16'h001C});
    // stored key shorter than the query must not match on its zero slots
    send_key_item(skt_pkg::OP_PREFIX, 4, {16'h0000, 16'h0001, 16'hE01C, 16'h001C});
    send_key_item(skt_pkg::OP_EXACT,  1, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000});
    send_key_item(skt_pkg::OP_EXACT,  4, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_key_item(skt_pkg::OP_PREFIX, 2, {16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF});
    send_key_item(skt_pkg::OP_EXACT,  3, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_key_item(skt_pkg::OP_ADD,    0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_key_item(skt_pkg::OP_EXACT,  5, {16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF});
    send_key_item(skt_pkg::OP_PREFIX, 6, {16'h0000, 16'h0001, 16'hE01C, 16'h001C});
    send_key_item(skt_pkg::OP_ADD,    7, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_key_item(skt_pkg::OP_NONE,   2, {16'h0000, 16'h0000, 16'hE01C, 16'h001C});
    send_key_item(skt_pkg::OP_NONE,   0, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_key_item(skt_pkg::OP_NONE,   7, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
  endtask

  task automatic random_key_item();
    key_seq_t                   codes;
    logic [skt_pkg::OpW-1:0]    op;
    logic [skt_pkg::CountW-1:0] cnt;
    int                         roll;
    int                         pick;
    int                         k;
    for (k = 0; k < skt_pkg::InputCodes; k++) codes[k] = skt_pkg::CodeW'($urandom_range(0, 65535));
    roll = $urandom_range(0, 99);
    if (roll < 22) begin
      op  = skt_pkg::OP_ADD;
      cnt = skt_pkg::CountW'($urandom_range(1, MaxCodes));
      for (k = 0; k < cnt; k++) codes[k] = draw_scan_code();
      // extend or repeat a stored key now and then
      if (known_codes.size() > 0 && $urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, known_codes.size() - 1);
        for (k = 0; k < known_len[pick] && k < cnt; k++) codes[k] = known_codes[pick][k];
      end
    end else if (roll < 75 && known_codes.size() > 0) begin
      pick = $urandom_range(0, known_codes.size() - 1);
      op   = (roll < 52) ? skt_pkg::OP_EXACT : skt_pkg::OP_PREFIX;
      cnt  = (op == skt_pkg::OP_EXACT) ? skt_pkg::CountW'(known_len[pick])
                                       : skt_pkg::CountW'($urandom_range(1, known_len[pick]));
      for (k = 0; k < cnt; k++) codes[k] = known_codes[pick][k];
    end else if (roll < 90) begin
      op  = $urandom_range(0, 1) ? skt_pkg::OP_EXACT : skt_pkg::OP_PREFIX;
      cnt = skt_pkg::CountW'($urandom_range(1, MaxCodes));
      for (k = 0; k < cnt; k++) codes[k] = draw_scan_code();
    end else if (roll < 95) begin
      case ($urandom_range(0, 2))
        0:       op = skt_pkg::OP_ADD;
        1:       op = skt_pkg::OP_EXACT;
        default: op = skt_pkg::OP_PREFIX;
      endcase
      cnt = ($urandom_range(0, 3) == 0) ? '0
                                        : skt_pkg::CountW'($urandom_range(MaxCodes + 1, 7));
    end else begin
      op  = skt_pkg::OP_NONE;
      cnt = skt_pkg::CountW'($urandom_range(0, 7));
    end
    send_key_item(op, cnt, codes);
  endtask

  initial begin
    key_seq_t codes;
    int       phase;
    int       n;
    int       k;
    int       guard;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_keys();
    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_plan[phase];
      stall_pct = stall_plan[phase];
      for (n = 0; n < RandomItems / 4; n++) random_key_item();
    end
    // top the table up, then push against the limit and walk the full table
    while (known_codes.size() < TableEntries) begin
      for (k = 0; k < skt_pkg::InputCodes; k++) codes[k] = draw_scan_code();
      send_key_item(skt_pkg::OP_ADD, skt_pkg::CountW'($urandom_range(1, MaxCodes)), codes);
    end
    send_key_item(skt_pkg::OP_ADD, 1, {16'h0000, 16'h0000, 16'h0000, 16'h0001});
    send_key_item(skt_pkg::OP_ADD, 4, {16'h1111, 16'h2222, 16'h3333, 16'h4444});
    send_key_item(skt_pkg::OP_EXACT, 4, {16'h1111, 16'h2222, 16'h3333, 16'h4444});
    send_key_item(skt_pkg::OP_PREFIX, 1, known_codes[0]);
    in_valid <= 1'b0;

    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 100000);
    repeat (DrainCycles) @(posedge clk);

    $display("ran %0d items through four handshake phases up to a full table",
             items_sent);
    $display("searches that found a key: %0d, adds refused as full: %0d",
             found_count, full_count);
    if (pending != 0) $display("results still outstanding: %0d", pending);
    if (error_count == 0 && pending == 0) begin
      $display("[scan_code_key_table] OK");
    end else begin
      $display("[scan_code_key_table] ERROR");
    end
    $finish;
  end

  // several times the slowest legal run: every search walking all entries under stalls
  initial begin
    #10_000_000;
    $display("[scan_code_key_table] ERROR");
    $finish;
  end

endmodule
